// ===== hdl/nkro_pkg.sv =====
// Shared types and constants for the NKRO keyboard report builder.
`timescale 1ns / 1ps

package nkro_pkg;

    localparam logic [7:0] KC_NONE      = 8'h00;
    localparam logic [7:0] KC_MOD_FIRST = 8'hE0;
    localparam logic [7:0] KC_MOD_LAST  = 8'hE7;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_UPDATE      = 2'd0,
        OP_UPDATE_SEND = 2'd1,
        OP_SEND        = 2'd2,
        OP_CLEAR_SEND  = 2'd3
    } op_t;

    typedef enum logic {
        KIND_BYTE   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_CHECK,
        ST_EMIT,
        ST_STATUS
    } state_t;

endpackage

// ===== hdl/nkro_keyboard_report_builder_unit.sv =====
// N-key-rollover keyboard report builder: 1 + BITMAP_BYTES byte report held in block RAM.
// Each input beat is one command (s_tuser): update a key, update and send, send, or clear
// all and send. A key update is a read-modify-write of one report byte; a rejected keycode
// skips the RAM. A send that finds the report changed streams the whole report out of the
// report RAM, one byte per cycle while m_tready does not stall it. Every command ends with
// a status beat; the next command is taken only once that beat is in the output register.
// A running count of differing bytes between the report and the last-sent copy makes the
// change check a single compare.
// Both RAMs reset to zero through per-entry valid bits; there is no clearing pass.
`timescale 1ns / 1ps

module nkro_keyboard_report_builder_unit
    import nkro_pkg::*;
#(
    parameter int BITMAP_BYTES = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // keycode[7:0], pressed[8], zero[15:9]
    input  logic [1:0]            s_tuser,   // op[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // report_byte[7:0], byte_position[13:8],
                                             // accepted[14], report_sent[15]
    output logic                  m_tuser,   // kind[0]
    output logic                  m_tlast
);

    localparam int REPORT_BYTES = BITMAP_BYTES + 1;
    localparam int AW           = $clog2(REPORT_BYTES);
    localparam int CW           = $clog2(REPORT_BYTES + 1);
    localparam logic [AW-1:0] LAST_POS = AW'(REPORT_BYTES - 1);

    // report RAM and last-sent RAM
    logic [7:0] cur_mem  [REPORT_BYTES];
    logic [7:0] sent_mem [REPORT_BYTES];

    state_t state_reg, state_next;

    op_t                    op_reg, op_next;
    logic [AW-1:0]          key_idx_reg, key_idx_next;
    logic [2:0]             key_bit_reg, key_bit_next;
    logic                   pressed_reg, pressed_next;
    logic                   accepted_reg, accepted_next;
    logic                   sent_flag_reg, sent_flag_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          diff_cnt_reg, diff_cnt_next;
    logic [CW-1:0]          sent_nz_reg, sent_nz_next;
    logic [REPORT_BYTES-1:0] cur_vld_reg, cur_vld_next;
    logic [REPORT_BYTES-1:0] sent_vld_reg, sent_vld_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;
    logic                   m_tlast_reg, m_tlast_next;

    logic [7:0]    cur_rd_reg, sent_rd_reg;
    logic          cur_rd_ok_reg, sent_rd_ok_reg;

    logic          cur_re, cur_we, sent_re, sent_we;
    logic [AW-1:0] cur_raddr, cur_waddr, sent_raddr, sent_waddr;
    logic [7:0]    cur_wdata, sent_wdata;

    logic          in_accept, out_free;
    logic [7:0]    in_keycode;
    logic          in_pressed;
    op_t           in_op;
    logic          in_is_mod, in_key_ok, in_is_key_op;
    logic [AW-1:0] in_key_idx;

    logic [7:0]    cur_eff, sent_eff, key_mask, new_byte;

    assign in_keycode = s_tdata[7:0];
    assign in_pressed = s_tdata[8];
    assign in_op      = op_t'(s_tuser);
    assign in_accept  = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;

    assign in_is_mod    = (in_keycode >= KC_MOD_FIRST) && (in_keycode <= KC_MOD_LAST);
    assign in_key_ok    = (in_keycode != KC_NONE) && (in_keycode <= KC_MOD_LAST) &&
                          (in_is_mod || ({1'b0, in_keycode[7:3]} < 6'(BITMAP_BYTES)));
    assign in_key_idx   = in_is_mod ? '0 : AW'(in_keycode[7:3]) + AW'(1);
    assign in_is_key_op = (in_op == OP_UPDATE) || (in_op == OP_UPDATE_SEND);

    assign cur_eff  = cur_rd_ok_reg ? cur_rd_reg : 8'h00;
    assign sent_eff = sent_rd_ok_reg ? sent_rd_reg : 8'h00;
    assign key_mask = 8'h01 << key_bit_reg;
    assign new_byte = pressed_reg ? (cur_eff | key_mask) : (cur_eff & ~key_mask);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_is_key_op) begin
                        state_next = in_key_ok ? ST_MODIFY : ST_STATUS;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_MODIFY: begin
                state_next = (op_reg == OP_UPDATE_SEND) ? ST_CHECK : ST_STATUS;
            end
            ST_CHECK: begin
                state_next = (diff_cnt_reg != '0) ? ST_EMIT : ST_STATUS;
            end
            ST_EMIT: begin
                if (out_free && (pos_reg == LAST_POS)) begin
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        op_next        = op_reg;
        key_idx_next   = key_idx_reg;
        key_bit_next   = key_bit_reg;
        pressed_next   = pressed_reg;
        accepted_next  = accepted_reg;
        sent_flag_next = sent_flag_reg;
        pos_next       = pos_reg;
        diff_cnt_next  = diff_cnt_reg;
        sent_nz_next   = sent_nz_reg;
        cur_vld_next   = cur_vld_reg;
        sent_vld_next  = sent_vld_reg;

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        cur_re     = 1'b0;
        cur_raddr  = key_idx_reg;
        cur_we     = 1'b0;
        cur_waddr  = key_idx_reg;
        cur_wdata  = new_byte;
        sent_re    = 1'b0;
        sent_raddr = in_key_idx;
        sent_we    = 1'b0;
        sent_waddr = pos_reg;
        sent_wdata = cur_eff;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    op_next        = in_op;
                    key_idx_next   = in_key_idx;
                    key_bit_next   = in_keycode[2:0];
                    pressed_next   = in_pressed;
                    accepted_next  = in_is_key_op ? in_key_ok : 1'b1;
                    sent_flag_next = 1'b0;
                    if (in_is_key_op && in_key_ok) begin
                        cur_re    = 1'b1;
                        cur_raddr = in_key_idx;
                        sent_re   = 1'b1;
                    end
                    if (in_op == OP_CLEAR_SEND) begin
                        cur_vld_next  = '0;
                        diff_cnt_next = sent_nz_reg;
                    end
                end
            end
            ST_MODIFY: begin
                cur_we                    = 1'b1;
                cur_vld_next[key_idx_reg] = 1'b1;
                diff_cnt_next = diff_cnt_reg - CW'(cur_eff != sent_eff)
                                             + CW'(new_byte != sent_eff);
            end
            ST_CHECK: begin
                if (diff_cnt_reg != '0) begin
                    cur_re         = 1'b1;
                    cur_raddr      = '0;
                    pos_next       = '0;
                    diff_cnt_next  = '0;
                    sent_nz_next   = '0;
                    sent_flag_next = 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, 1'b0, 6'(pos_reg), cur_eff};
                    m_tuser_next  = KIND_BYTE;
                    m_tlast_next  = 1'b0;
                    sent_we                = 1'b1;
                    sent_vld_next[pos_reg] = 1'b1;
                    sent_nz_next = sent_nz_reg + CW'(cur_eff != 8'h00);
                    if (pos_reg != LAST_POS) begin
                        cur_re    = 1'b1;
                        cur_raddr = pos_reg + AW'(1);
                        pos_next  = pos_reg + AW'(1);
                    end
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {sent_flag_reg, accepted_reg, 6'd0, 8'h00};
                    m_tuser_next  = KIND_STATUS;
                    m_tlast_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            diff_cnt_reg <= '0;
            sent_nz_reg  <= '0;
            cur_vld_reg  <= '0;
            sent_vld_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            diff_cnt_reg <= diff_cnt_next;
            sent_nz_reg  <= sent_nz_next;
            cur_vld_reg  <= cur_vld_next;
            sent_vld_reg <= sent_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_idx_reg   <= key_idx_next;
        key_bit_reg   <= key_bit_next;
        pressed_reg   <= pressed_next;
        accepted_reg  <= accepted_next;
        sent_flag_reg <= sent_flag_next;
        pos_reg       <= pos_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        m_tlast_reg   <= m_tlast_next;
    end

    always_ff @(posedge aclk) begin
        if (cur_we) begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        if (cur_re) begin
            cur_rd_reg    <= cur_mem[cur_raddr];
            cur_rd_ok_reg <= cur_vld_next[cur_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (sent_we) begin
            sent_mem[sent_waddr] <= sent_wdata;
        end
        if (sent_re) begin
            sent_rd_reg    <= sent_mem[sent_raddr];
            sent_rd_ok_reg <= sent_vld_reg[sent_raddr];
        end
    end

endmodule

// ===== dv/nkro_keyboard_report_builder_unit_tb.sv =====
// Self-checking testbench for the NKRO keyboard report builder.
`timescale 1ns / 1ps

module nkro_keyboard_report_builder_unit_tb;
    import nkro_pkg::*;

    localparam int BITMAP_BYTES = 32;
    localparam int REPORT_BYTES = BITMAP_BYTES + 1;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        op_t        op;
        logic [7:0] keycode;
        logic       pressed;
        logic       wait_idle;
    } key_cmd_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] rbyte;
        logic [5:0] pos;
        logic       acc;
        logic       sent;
        logic       last;
    } report_beat_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;     // keycode[7:0], pressed[8], zero[15:9]
    logic [1:0]            s_tuser = '0;     // op[1:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // report_byte[7:0], byte_position[13:8],
                                             // accepted[14], report_sent[15]
    logic                  m_tuser;          // kind[0]
    logic                  m_tlast;

    key_cmd_t     pending_cmds[$];
    report_beat_t report_beats_due[$];
    key_cmd_t     cmd_on_bus;

    logic [7:0] report_now  [REPORT_BYTES];
    logic [7:0] report_sent [REPORT_BYTES];

    int cmds_taken = 0;
    int status_seen = 0;
    int mismatches = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    nkro_keyboard_report_builder_unit #(
        .BITMAP_BYTES(BITMAP_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial forever #4 aclk = ~aclk;

    initial begin
        for (int i = 0; i < REPORT_BYTES; i++) begin
            report_now[i]  = 8'h00;
            report_sent[i] = 8'h00;
        end
    end

    // Expected beats for one accepted command; updates the report model.
    function automatic void predict_report(key_cmd_t c);
        logic       ok;
        logic       do_send;
        logic       differs;
        logic [7:0] mask;
        int         idx;
        report_beat_t b;
        ok = 1'b1;
        do_send = 1'b0;
        differs = 1'b0;
        mask = 8'h00;
        idx = 0;
        case (c.op)
            OP_UPDATE, OP_UPDATE_SEND: begin
                if (c.keycode == KC_NONE || c.keycode > KC_MOD_LAST) begin
                    ok = 1'b0;
                end else if (c.keycode >= KC_MOD_FIRST) begin
                    idx = 0;
                    mask = 8'h01 << (c.keycode - KC_MOD_FIRST);
                end else if (int'(c.keycode >> 3) >= BITMAP_BYTES) begin
                    ok = 1'b0;
                end else begin
                    idx = 1 + int'(c.keycode >> 3);
                    mask = 8'h01 << c.keycode[2:0];
                end
                if (ok) begin
                    report_now[idx] = c.pressed ? (report_now[idx] | mask)
                                                : (report_now[idx] & ~mask);
                end
                do_send = ok && (c.op == OP_UPDATE_SEND);
            end
            OP_SEND: begin
                do_send = 1'b1;
            end
            default: begin
                for (int i = 0; i < REPORT_BYTES; i++) report_now[i] = 8'h00;
                do_send = 1'b1;
            end
        endcase
        if (do_send) begin
            for (int i = 0; i < REPORT_BYTES; i++) begin
                if (report_now[i] != report_sent[i]) differs = 1'b1;
            end
        end
        if (differs) begin
            for (int i = 0; i < REPORT_BYTES; i++) begin
                b = '{KIND_BYTE, report_now[i], 6'(i), 1'b0, 1'b0, 1'b0};
                report_beats_due.push_back(b);
                report_sent[i] = report_now[i];
            end
        end
        b = '{KIND_STATUS, 8'h00, 6'd0, ok, differs, 1'b1};
        report_beats_due.push_back(b);
    endfunction

    task automatic queue_cmd(op_t op, logic [7:0] kc, logic pressed, logic wait_idle);
        key_cmd_t c;
        c = '{op, kc, pressed, wait_idle};
        pending_cmds.push_back(c);
    endtask

    // Sender: one command per beat, random gaps except in a calm window.
    always @(posedge aclk) begin
        logic offer;
        logic calm;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_report(cmd_on_bus);
                cmds_taken++;
            end
            if (!s_tvalid || s_tready) begin
                calm = (cmds_taken >= 120 && cmds_taken < 170);
                offer = 1'b0;
                if (pending_cmds.size() > 0
                    && !(pending_cmds[0].wait_idle && report_beats_due.size() > 0)
                    && (calm || $urandom_range(99) >= 31)) begin
                    cmd_on_bus = pending_cmds.pop_front();
                    offer = 1'b1;
                    s_tdata <= {7'b0, cmd_on_bus.pressed, cmd_on_bus.keycode};
                    s_tuser <= cmd_on_bus.op;
                end
                s_tvalid <= offer;
            end
        end
    end

    // Receiver: checks each beat against the oldest expectation.
    always @(posedge aclk) begin
        report_beat_t got;
        report_beat_t want;
        logic calm;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{kind_t'(m_tuser), m_tdata[7:0], m_tdata[13:8], m_tdata[14],
                        m_tdata[15], m_tlast};
                if (report_beats_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected beat: kind %0d byte %02h pos %0d acc %0b sent %0b last %0b",
                                 got.kind, got.rbyte, got.pos, got.acc, got.sent, got.last);
                    end
                end else begin
                    want = report_beats_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp: kind %0d byte %02h pos %0d acc %0b sent %0b last %0b",
                                     want.kind, want.rbyte, want.pos, want.acc, want.sent,
                                     want.last);
                            $display("         got: kind %0d byte %02h pos %0d acc %0b sent %0b last %0b",
                                     got.kind, got.rbyte, got.pos, got.acc, got.sent, got.last);
                        end
                    end
                end
                if (m_tlast) status_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done && status_seen >= 30) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            calm = (status_seen >= 130 && status_seen < 175);
            m_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 31);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] kc;
        int         r;
        op_t        op;

        // directed
        queue_cmd(OP_SEND,        8'h00, 1'b0, 1'b0);   // unchanged report after reset
        queue_cmd(OP_UPDATE,      8'h00, 1'b1, 1'b0);   // keycode 0 rejected
        queue_cmd(OP_UPDATE_SEND, 8'h00, 1'b1, 1'b0);
        queue_cmd(OP_UPDATE_SEND, 8'hE8, 1'b1, 1'b0);   // just past modifiers
        queue_cmd(OP_UPDATE_SEND, 8'hFF, 1'b1, 1'b0);
        queue_cmd(OP_UPDATE,      8'hE0, 1'b1, 1'b0);
        queue_cmd(OP_UPDATE_SEND, 8'hE7, 1'b1, 1'b0);
        queue_cmd(OP_UPDATE_SEND, 8'h01, 1'b1, 1'b0);
        queue_cmd(OP_UPDATE_SEND, 8'hDF, 1'b1, 1'b0);
        queue_cmd(OP_UPDATE_SEND, 8'h04, 1'b1, 1'b0);
        queue_cmd(OP_SEND,        8'hFF, 1'b1, 1'b0);   // unchanged, key fields ignored
        queue_cmd(OP_UPDATE,      8'h04, 1'b0, 1'b0);
        queue_cmd(OP_UPDATE_SEND, 8'h04, 1'b1, 1'b0);   // back to the sent copy
        queue_cmd(OP_UPDATE,      8'hAA, 1'b1, 1'b0);
        queue_cmd(OP_UPDATE,      8'h55, 1'b1, 1'b0);
        queue_cmd(OP_SEND,        8'h00, 1'b0, 1'b0);
        queue_cmd(OP_UPDATE_SEND, 8'hE0, 1'b0, 1'b0);
        queue_cmd(OP_CLEAR_SEND,  8'hFF, 1'b1, 1'b0);
        queue_cmd(OP_CLEAR_SEND,  8'h00, 1'b0, 1'b0);   // already clear
        queue_cmd(OP_UPDATE_SEND, 8'h01, 1'b0, 1'b0);   // release of a released key
        queue_cmd(OP_UPDATE_SEND, 8'hE7, 1'b0, 1'b0);

        // random: mostly valid keys from a small pool so releases hit held keys
        for (int n = 0; n < 200; n++) begin
            r = $urandom_range(99);
            if (r < 40)      kc = 8'($urandom_range(16, 1));
            else if (r < 65) kc = 8'($urandom_range(8'hE7, 8'hE0));
            else if (r < 90) kc = 8'($urandom_range(8'hDF, 1));
            else if (r < 95) kc = KC_NONE;
            else             kc = 8'($urandom_range(8'hFF, 8'hE8));
            r = $urandom_range(99);
            if (r < 30)      op = OP_UPDATE;
            else if (r < 75) op = OP_UPDATE_SEND;
            else if (r < 92) op = OP_SEND;
            else             op = OP_CLEAR_SEND;
            queue_cmd(op, kc, 1'($urandom_range(1)), 1'(n == 100));
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (pending_cmds.size() > 0 || s_tvalid || report_beats_due.size() > 0);
        repeat (40) @(posedge aclk);

        if (mismatches == 0 && report_beats_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
